// ===== sv/cps_pkg.sv =====
// Shared types and constants for the counter priority task scheduler.
package cps_pkg;

    localparam int MODE_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int PRIO_W  = 8;
    localparam int START_W = 9;
    localparam int PRE_W   = 8;
    localparam int CNT_W   = 16;

    localparam int REFILL_LIMIT = 20;
    localparam int PASS_W       = $clog2(REFILL_LIMIT + 1);

    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_YIELD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PDIS    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEN     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INSTALL = 3'd4;

    localparam logic [PRE_W-1:0]        PRE_MAX = '1;
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic signed [CNT_W-1:0] CNT_NONE = '1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_YIELD,
        OP_PDIS,
        OP_PEN,
        OP_INSTALL,
        OP_REFILL,
        OP_SWITCH
    } op_t;

    // Command broadcast to every cell in the same cycle.
    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic               present;
        logic               runnable;
        logic [PRIO_W-1:0]  prio;
        logic [START_W-1:0] start_cnt;
        logic [PRE_W-1:0]   start_pre;
    } cmd_t;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic                    valid;
        logic signed [CNT_W-1:0] best;
        logic signed [CNT_W-1:0] pick_cnt;
        logic [PRE_W-1:0]        pick_pre;
        logic signed [CNT_W-1:0] run_cnt;
        logic [PRE_W-1:0]        run_pre;
    } tok_t;

endpackage

// ===== sv/cps_cell.sv =====
// One task slot cell: holds the slot state and forwards the scan token.
module cps_cell #(
    parameter int TASK_SLOTS = 64,
    parameter int INDEX      = 0,
    localparam int IDX_W     = $clog2(TASK_SLOTS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cps_pkg::cmd_t      cmd,
    input  logic [IDX_W-1:0]   cmd_pick,
    input  cps_pkg::tok_t      tok_in,
    input  logic [IDX_W-1:0]   tok_pick_in,
    output cps_pkg::tok_t      tok_out,
    output logic [IDX_W-1:0]   tok_pick_out
);
    import cps_pkg::*;

    localparam logic IS_HEAD = (INDEX == 0);

    logic                    present_reg, present_next;
    logic                    runnable_reg, runnable_next;
    logic [PRIO_W-1:0]       prio_reg, prio_next;
    logic signed [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PRE_W-1:0]        pre_reg, pre_next;
    logic                    run_reg, run_next;
    tok_t                    tok_reg, tok_next;
    logic [IDX_W-1:0]        tok_pick_reg, tok_pick_next;

    logic signed [CNT_W-1:0] cnt_dec;
    logic [PRE_W-1:0]        pre_inc, pre_dec;
    logic                    is_pick, is_slot, cand;

    assign cnt_dec = (cnt_reg == CNT_MIN) ? cnt_reg : cnt_reg - 1'b1;
    assign pre_inc = (pre_reg == PRE_MAX) ? pre_reg : pre_reg + 1'b1;
    assign pre_dec = (pre_reg == '0) ? pre_reg : pre_reg - 1'b1;
    assign is_pick = (cmd_pick == IDX_W'(INDEX));
    assign is_slot = (32'(cmd.slot) == 32'(INDEX));
    assign cand    = present_reg && runnable_reg && ($signed(cnt_reg) > $signed(tok_in.best));

    always_comb begin
        present_next  = present_reg;
        runnable_next = runnable_reg;
        prio_next     = prio_reg;
        cnt_next      = cnt_reg;
        pre_next      = pre_reg;
        run_next      = run_reg;
        case (cmd.op)
            OP_TICK: begin
                if (run_reg) begin
                    if ((cnt_dec[CNT_W-1] || cnt_dec == '0) && pre_reg == '0) begin
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_dec;
                    end
                end
            end
            OP_YIELD: begin
                if (run_reg) cnt_next = '0;
            end
            OP_PDIS: begin
                if (run_reg) pre_next = pre_inc;
            end
            OP_PEN: begin
                if (run_reg) pre_next = pre_dec;
            end
            OP_INSTALL: begin
                if (is_slot) begin
                    present_next  = cmd.present;
                    runnable_next = cmd.runnable;
                    prio_next     = cmd.prio;
                    cnt_next      = CNT_W'(cmd.start_cnt);
                    pre_next      = cmd.start_pre;
                end
            end
            OP_REFILL: begin
                if (present_reg) begin
                    cnt_next = (cnt_reg >>> 1) + $signed({{(CNT_W-PRIO_W){1'b0}}, prio_reg});
                end
            end
            OP_SWITCH: begin
                if (run_reg && !is_pick) begin
                    run_next = 1'b0;
                    pre_next = pre_inc;
                end else if (is_pick && !run_reg) begin
                    run_next = 1'b1;
                    pre_next = pre_dec;
                end
            end
            default: ;
        endcase
    end

    // Keep the largest counter so far; ties keep the earlier slot.
    always_comb begin
        tok_next      = tok_in;
        tok_pick_next = tok_pick_in;
        if (cand) begin
            tok_next.best     = cnt_reg;
            tok_next.pick_cnt = cnt_reg;
            tok_next.pick_pre = pre_reg;
            tok_pick_next     = IDX_W'(INDEX);
        end else if (IS_HEAD) begin
            tok_next.pick_cnt = cnt_reg;
            tok_next.pick_pre = pre_reg;
        end
        if (run_reg) begin
            tok_next.run_cnt = cnt_reg;
            tok_next.run_pre = pre_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg  <= IS_HEAD;
            runnable_reg <= IS_HEAD;
            prio_reg     <= IS_HEAD ? PRIO_W'(1) : '0;
            cnt_reg      <= '0;
            pre_reg      <= IS_HEAD ? PRE_W'(1) : '0;
            run_reg      <= IS_HEAD;
            tok_reg      <= '0;
            tok_pick_reg <= '0;
        end else begin
            present_reg  <= present_next;
            runnable_reg <= runnable_next;
            prio_reg     <= prio_next;
            cnt_reg      <= cnt_next;
            pre_reg      <= pre_next;
            run_reg      <= run_next;
            tok_reg      <= tok_next;
            tok_pick_reg <= tok_pick_next;
        end
    end

    assign tok_out      = tok_reg;
    assign tok_pick_out = tok_pick_reg;

endmodule

// ===== sv/counter_priority_task_scheduler_top.sv =====
// Top level of the counter priority task scheduler: sequencer and cell chain.
//
// Input channel (s_valid/s_ready): one event per transfer. s_mode selects
// tick, yield, preempt disable, preempt enable or install; the install
// fields are used only by install. s_ready is high while the sequencer is
// idle, so one event is in flight at a time.
// Result channel (m_valid/m_ready): one result per event, held in an output
// register until its transfer. The next event is taken while a result still
// waits; the sequencer only holds at its final step if the previous result
// has not gone out.
// Sequence: each event is broadcast to the cells, then a scan token walks
// the chain of TASK_SLOTS cells one cell a cycle. Each counter refill adds
// one refill broadcast plus a new walk, up to REFILL_LIMIT refills; a task
// switch adds a switch broadcast before the final step.
// Reset (aresetn low, synchronous): slot 0 is present, runnable, priority 1,
// preempt count 1 and running; all other slots are clear, all counters zero.
// A stalled receiver only delays the final step; no result is lost.
module counter_priority_task_scheduler_top #(
    parameter int TASK_SLOTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cps_pkg::MODE_W-1:0]    s_mode,
    input  logic [cps_pkg::SLOT_W-1:0]    s_slot,
    input  logic                          s_present,
    input  logic                          s_runnable,
    input  logic [cps_pkg::PRIO_W-1:0]    s_priority_req,
    input  logic [cps_pkg::START_W-1:0]   s_start_counter,
    input  logic [cps_pkg::PRE_W-1:0]     s_start_preempt,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cps_pkg::SLOT_W-1:0]    m_current_task,
    output logic [cps_pkg::SLOT_W-1:0]    m_previous_task,
    output logic                          m_switched,
    output logic signed [cps_pkg::CNT_W-1:0] m_current_counter,
    output logic [cps_pkg::PRE_W-1:0]     m_current_preempt
);
    import cps_pkg::*;

    localparam int IDX_W = $clog2(TASK_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_LAUNCH,
        ST_WAIT,
        ST_REFILL,
        ST_SWITCH,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [IDX_W-1:0]        running_reg;
    logic [IDX_W-1:0]        prev_reg;
    logic [IDX_W-1:0]        pick_reg;
    logic [PASS_W-1:0]       pass_reg;
    logic                    sched_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    present_reg;
    logic                    runnable_reg;
    logic [PRIO_W-1:0]       prio_reg;
    logic [START_W-1:0]      start_cnt_reg;
    logic [PRE_W-1:0]        start_pre_reg;
    logic signed [CNT_W-1:0] res_cnt_reg;
    logic [PRE_W-1:0]        res_pre_reg;
    logic                    m_valid_reg;

    cmd_t                    cmd;
    tok_t                    tok_chain  [TASK_SLOTS+1];
    logic [IDX_W-1:0]        pick_chain [TASK_SLOTS+1];
    tok_t                    tok_end;
    logic [IDX_W-1:0]        pick_end;
    logic                    resched;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Broadcast command to the cells.
    always_comb begin
        cmd.slot      = slot_reg;
        cmd.present   = present_reg;
        cmd.runnable  = runnable_reg;
        cmd.prio      = prio_reg;
        cmd.start_cnt = start_cnt_reg;
        cmd.start_pre = start_pre_reg;
        cmd.op        = OP_NONE;
        case (state_reg)
            ST_APPLY: begin
                case (mode_reg)
                    MODE_TICK:    cmd.op = OP_TICK;
                    MODE_YIELD:   cmd.op = OP_YIELD;
                    MODE_PDIS:    cmd.op = OP_PDIS;
                    MODE_PEN:     cmd.op = OP_PEN;
                    MODE_INSTALL: cmd.op = OP_INSTALL;
                    default:      cmd.op = OP_NONE;
                endcase
            end
            ST_REFILL: cmd.op = OP_REFILL;
            ST_SWITCH: cmd.op = OP_SWITCH;
            default:   cmd.op = OP_NONE;
        endcase
    end

    // Launch a fresh token into the head of the chain.
    always_comb begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = (state_reg == ST_LAUNCH);
        tok_chain[0].best  = CNT_NONE;
        pick_chain[0]      = '0;
    end

    for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
        cps_cell #(
            .TASK_SLOTS (TASK_SLOTS),
            .INDEX      (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd          (cmd),
            .cmd_pick     (pick_reg),
            .tok_in       (tok_chain[i]),
            .tok_pick_in  (pick_chain[i]),
            .tok_out      (tok_chain[i+1]),
            .tok_pick_out (pick_chain[i+1])
        );
    end

    assign tok_end  = tok_chain[TASK_SLOTS];
    assign pick_end = pick_chain[TASK_SLOTS];

    // Reschedule on yield, or on a tick that left the counter spent with
    // preemption enabled; once a refill has run the decision is latched.
    assign resched = sched_reg || (mode_reg == MODE_YIELD) ||
                     ((mode_reg == MODE_TICK) &&
                      (tok_end.run_cnt[CNT_W-1] || tok_end.run_cnt == '0) &&
                      (tok_end.run_pre == '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            running_reg <= '0;
            prev_reg    <= '0;
            pick_reg    <= '0;
            pass_reg    <= '0;
            sched_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // the final step drives valid itself
            if (m_ready && state_reg != ST_FINISH) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg      <= s_mode;
                        slot_reg      <= s_slot;
                        present_reg   <= s_present;
                        runnable_reg  <= s_runnable;
                        prio_reg      <= s_priority_req;
                        start_cnt_reg <= s_start_counter;
                        start_pre_reg <= s_start_preempt;
                        prev_reg      <= running_reg;
                        sched_reg     <= 1'b0;
                        pass_reg      <= '0;
                        state_reg     <= ST_APPLY;
                    end
                end
                ST_APPLY:  state_reg <= ST_LAUNCH;
                ST_LAUNCH: state_reg <= ST_WAIT;
                ST_REFILL: state_reg <= ST_LAUNCH;
                ST_WAIT: begin
                    if (tok_end.valid) begin
                        if (resched && tok_end.best == '0 &&
                            pass_reg < PASS_W'(REFILL_LIMIT)) begin
                            // every candidate is spent: refill and walk again
                            sched_reg <= 1'b1;
                            pass_reg  <= pass_reg + 1'b1;
                            state_reg <= ST_REFILL;
                        end else if (resched && pick_end != running_reg) begin
                            pick_reg    <= pick_end;
                            res_cnt_reg <= tok_end.pick_cnt;
                            res_pre_reg <= (tok_end.pick_pre == '0) ?
                                           tok_end.pick_pre : tok_end.pick_pre - 1'b1;
                            state_reg   <= ST_SWITCH;
                        end else begin
                            res_cnt_reg <= tok_end.run_cnt;
                            res_pre_reg <= tok_end.run_pre;
                            state_reg   <= ST_FINISH;
                        end
                    end
                end
                ST_SWITCH: begin
                    running_reg <= pick_reg;
                    state_reg   <= ST_FINISH;
                end
                ST_FINISH: begin
                    // hold until the previous result has been transferred
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_current_task    <= SLOT_W'(running_reg);
                        m_previous_task   <= SLOT_W'(prev_reg);
                        m_switched        <= (running_reg != prev_reg);
                        m_current_counter <= res_cnt_reg;
                        m_current_preempt <= res_pre_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
